>>> rtl/gradient_noise_turbulence_unit_macros.svh
// Assertion helpers used by the RTL.
`ifndef GRADIENT_NOISE_TURBULENCE_UNIT_MACROS_SVH
`define GRADIENT_NOISE_TURBULENCE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GNT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gnt_pkg.sv
`timescale 1ns / 1ps
package gnt_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = 8;
	localparam int GRAD_W     = 16;
	localparam int GRAD_FRAC  = 14;
	localparam int OUT_W      = 20;
	localparam int OUT_FRAC   = 16;
	localparam int OUT_MAX    = 524287;
	localparam int OUT_MIN    = -524288;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_NOISE = 2'd1;
	localparam logic [1:0] ACT_TURB  = 2'd2;

	localparam logic [2:0] LAST_CORNER = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH1,
		ST_SMOOTH2,
		ST_CORNER,
		ST_DRAIN,
		ST_FOLD,
		ST_DONE
	} gnt_state_t;

	typedef struct packed {
		logic       start;        // latch point, clear octave sum
		logic       turb;         // item is turbulence (abs on output)
		logic       write_tables; // load transfer writes the tables
		logic       clear_noise;  // clear corner accumulator
		logic       issue;        // send a corner down the pipe
		logic [2:0] corner;       // {di, dj, dk}
		logic       fold;         // add octave noise, double point
		logic       finish;       // load output register
	} gnt_cmd_t;

	typedef struct packed {
		logic busy; // corners still in flight
	} gnt_status_t;

endpackage

>>> rtl/gnt_ctrl.sv
`timescale 1ns / 1ps
`include "gradient_noise_turbulence_unit_macros.svh"
module gnt_ctrl #(
	parameter int MAX_OCTAVES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	input  logic [1:0]          action,
	input  logic [4:0]          octave_count,
	output logic                m_valid,
	input  logic                m_ready,
	input  gnt_pkg::gnt_status_t status,
	output gnt_pkg::gnt_cmd_t    cmd
);
	import gnt_pkg::*;

	localparam int CW = $clog2(MAX_OCTAVES + 1);

	gnt_state_t state_q, state_d;
	logic [CW-1:0] left_q;
	logic [2:0]    corner_q;
	logic          m_valid_q;
	logic          accept, is_eval, out_free;
	logic [5:0]    cnt_in;
	logic [CW-1:0] cnt_sat;

	assign s_ready  = (state_q == ST_IDLE);
	assign accept   = s_valid && s_ready;
	assign is_eval  = (action == ACT_NOISE) || (action == ACT_TURB);
	assign out_free = !m_valid_q || m_ready;
	assign m_valid  = m_valid_q;
	assign cnt_in   = {1'b0, octave_count};
	assign cnt_sat  = (cnt_in > 6'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(cnt_in);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_eval) begin
					if (action == ACT_TURB && cnt_sat == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SMOOTH1;
					end
				end
			end
			ST_SMOOTH1: state_d = ST_SMOOTH2;
			ST_SMOOTH2: state_d = ST_CORNER;
			ST_CORNER: begin
				if (corner_q == LAST_CORNER) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.busy) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (left_q == CW'(1)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SMOOTH1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd              = '0;
		cmd.start        = accept && is_eval;
		cmd.turb         = (action == ACT_TURB);
		cmd.write_tables = accept && (action == ACT_LOAD);
		cmd.clear_noise  = (state_q == ST_SMOOTH1);
		cmd.issue        = (state_q == ST_CORNER);
		cmd.corner       = corner_q;
		cmd.fold         = (state_q == ST_FOLD);
		cmd.finish       = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			left_q    <= '0;
			corner_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_eval) begin
				left_q <= (action == ACT_TURB) ? cnt_sat : CW'(1);
			end else if (cmd.fold) begin
				left_q <= left_q - CW'(1);
			end
			if (cmd.issue) begin
				corner_q <= corner_q + 3'd1;
			end
			if (cmd.finish) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	`GNT_ASSERT_IMP(a_finish_slot_free, clk, arst_n, cmd.finish, (!m_valid_q || m_ready), "result overwritten")
	`GNT_ASSERT_IMP(a_fold_after_drain, clk, arst_n, cmd.fold, !status.busy, "fold with corners in flight")
	`GNT_ASSERT_NXT(a_last_corner_drain, clk, arst_n, (state_q == ST_CORNER && corner_q == LAST_CORNER), (state_q == ST_DRAIN), "corner count wrong")

endmodule

>>> rtl/gnt_datapath.sv
`timescale 1ns / 1ps
module gnt_datapath #(
	parameter int FRAC_BITS   = 16,
	parameter int MAX_OCTAVES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gnt_pkg::gnt_cmd_t    cmd,
	output gnt_pkg::gnt_status_t status,
	input  logic [7:0]           table_index,
	input  logic [7:0]           perm_x_value,
	input  logic [7:0]           perm_y_value,
	input  logic [7:0]           perm_z_value,
	input  logic signed [15:0]   grad_x,
	input  logic signed [15:0]   grad_y,
	input  logic signed [15:0]   grad_z,
	input  logic [31:0]          point_x,
	input  logic [31:0]          point_y,
	input  logic [31:0]          point_z,
	output logic signed [19:0]   noise_value
);
	import gnt_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int CW  = $clog2(MAX_OCTAVES + 1);
	localparam int NW  = F + 12;      // octave noise
	localparam int AW  = 2 * F + 12;  // corner accumulator
	localparam int TW  = F + 14;      // octave sum
	localparam int CVW = TW + 16;     // output conversion
	localparam int SHR = (F >= OUT_FRAC) ? F - OUT_FRAC : 0;
	localparam int SHL = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
	localparam logic signed [CVW-1:0] SAT_HI = CVW'(OUT_MAX);
	localparam logic signed [CVW-1:0] SAT_LO = CVW'(OUT_MIN);

	// table storage
	logic [IDX_W-1:0]    perm_x_mem [TABLE_SIZE];
	logic [IDX_W-1:0]    perm_y_mem [TABLE_SIZE];
	logic [IDX_W-1:0]    perm_z_mem [TABLE_SIZE];
	logic [3*GRAD_W-1:0] grad_mem   [TABLE_SIZE];

	logic [31:0]    point_q [3];
	logic [F-1:0]   frac [3];
	logic [7:0]     cell_idx [3];
	logic [7:0]     addr [3];
	logic [2*F-1:0] ff [3];
	logic [F+1:0]   tpoly [3];
	logic [2*F+1:0] sprod [3];
	logic [F-1:0]   sq_q [3];
	logic [F:0]     s_q [3];
	logic [F:0]     lo [3];

	// corner pipe
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0]             c_s1, c_s2;
	logic [IDX_W-1:0]       px_s1, py_s1, pz_s1;
	logic [IDX_W-1:0]       gidx;
	logic [3*GRAD_W-1:0]    grad_s2;
	logic signed [F+1:0]    off [3];
	logic signed [F+17:0]   gp_s3 [3];
	logic [2*F+1:0]         wxy_s3;
	logic [F:0]             wz_s3;
	logic [F:0]             wx, wy;
	logic signed [F+19:0]   dsum;
	logic signed [F+5:0]    dot_s4;
	logic [2*F+1:0]         wprod;
	logic [F:0]             w_s4;
	logic signed [2*F+7:0]  prod_s5;

	logic signed [AW-1:0]  acc_q;
	logic signed [NW-1:0]  noise, nsh;
	logic signed [TW-1:0]  turb_q, mag;
	logic [CW-1:0]         oct_q;
	logic                  abs_q;
	logic signed [CVW-1:0] ext, conv;
	logic signed [OUT_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (cmd.write_tables) begin
			perm_x_mem[table_index] <= perm_x_value;
			perm_y_mem[table_index] <= perm_y_value;
			perm_z_mem[table_index] <= perm_z_value;
			grad_mem[table_index]   <= {grad_z, grad_y, grad_x};
		end
		px_s1   <= perm_x_mem[addr[0]];
		py_s1   <= perm_y_mem[addr[1]];
		pz_s1   <= perm_z_mem[addr[2]];
		grad_s2 <= grad_mem[gidx];
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			frac[a]     = point_q[a][F-1:0];
			cell_idx[a] = point_q[a][F+7:F];
			ff[a]       = frac[a] * frac[a];
			tpoly[a]    = {2'b11, {F{1'b0}}} - {1'b0, frac[a], 1'b0};
			sprod[a]    = sq_q[a] * tpoly[a];
			lo[a]       = {1'b1, {F{1'b0}}} - s_q[a];
		end
		addr[0] = cell_idx[0] + {7'd0, cmd.corner[2]};
		addr[1] = cell_idx[1] + {7'd0, cmd.corner[1]};
		addr[2] = cell_idx[2] + {7'd0, cmd.corner[0]};
		gidx    = px_s1 ^ py_s1 ^ pz_s1;
		for (int a = 0; a < 3; a++) begin
			if (c_s2[2-a]) begin
				off[a] = $signed({2'b00, frac[a]}) - $signed({2'b01, {F{1'b0}}});
			end else begin
				off[a] = $signed({2'b00, frac[a]});
			end
		end
		wx    = c_s2[2] ? s_q[0] : lo[0];
		wy    = c_s2[1] ? s_q[1] : lo[1];
		dsum  = gp_s3[0] + gp_s3[1] + gp_s3[2];
		wprod = wxy_s3[2*F:F] * wz_s3;
		noise = acc_q[AW-1:F];
		nsh   = noise >>> oct_q;
		mag   = (abs_q && turb_q < 0) ? -turb_q : turb_q;
		ext   = CVW'(mag);
		conv  = (ext <<< SHL) >>> SHR;
	end

	// point, smoothstep, datapath payload
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			sq_q[a] <= ff[a][2*F-1:F];
			s_q[a]  <= sprod[a][2*F:F];
		end
		if (cmd.start) begin
			point_q[0] <= point_x;
			point_q[1] <= point_y;
			point_q[2] <= point_z;
		end else if (cmd.fold) begin
			for (int a = 0; a < 3; a++) begin
				point_q[a] <= {point_q[a][30:0], 1'b0};
			end
		end
		c_s1 <= cmd.corner;
		c_s2 <= c_s1;
		gp_s3[0] <= $signed(grad_s2[15:0])  * off[0];
		gp_s3[1] <= $signed(grad_s2[31:16]) * off[1];
		gp_s3[2] <= $signed(grad_s2[47:32]) * off[2];
		wxy_s3   <= wx * wy;
		wz_s3    <= c_s2[0] ? s_q[2] : lo[2];
		dot_s4   <= dsum[F+19:GRAD_FRAC];
		w_s4     <= wprod[2*F:F];
		prod_s5  <= dot_s4 * $signed({1'b0, w_s4});
		if (cmd.clear_noise) begin
			acc_q <= '0;
		end else if (v_s5) begin
			acc_q <= acc_q + AW'(prod_s5);
		end
		if (cmd.start) begin
			turb_q <= '0;
			oct_q  <= '0;
			abs_q  <= cmd.turb;
		end else if (cmd.fold) begin
			turb_q <= turb_q + TW'(nsh);
			oct_q  <= oct_q + CW'(1);
		end
		if (cmd.finish) begin
			if (conv > SAT_HI) begin
				out_q <= OUT_W'(OUT_MAX);
			end else if (conv < SAT_LO) begin
				out_q <= OUT_W'(OUT_MIN);
			end else begin
				out_q <= conv[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign status.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign noise_value = out_q;

endmodule

>>> rtl/gradient_noise_turbulence_unit.sv
`timescale 1ns / 1ps
// 3-D gradient noise with turbulence. A transfer with tuser = load writes one
// entry of the three permutation tables and the gradient table (no result). A
// noise transfer evaluates one octave; a turbulence transfer sums octave_count
// octaves (capped at MAX_OCTAVES) and returns the magnitude, saturated to
// signed Q3.16. Items are handled one at a time: each octave runs two
// smoothstep multiplier steps, eight corner issues into the single
// lookup/multiply pipe and its drain, and one fold. Load transfers and new
// items are taken while a finished result still waits on the master side.
// Table entries must be written before they are read.
module gradient_noise_turbulence_unit #(
	parameter int MAX_OCTAVES = 16,  // 1..32
	parameter int FRAC_BITS   = 16   // 8..24, fraction bits of the point
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [7:0] table_index, [15:8] perm_x_value, [23:16] perm_y_value,
	// [31:24] perm_z_value, [47:32] grad_x, [63:48] grad_y, [79:64] grad_z,
	// [111:80] point_x, [143:112] point_y, [175:144] point_z,
	// [180:176] octave_count, rest zero
	input  logic [183:0] s_axis_tdata,
	// [1:0] action: load, noise, turbulence
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [19:0] noise_value, [23:20] zero
	output logic [23:0]  m_axis_tdata
);
	import gnt_pkg::*;

	gnt_cmd_t    cmd;
	gnt_status_t status;
	logic signed [OUT_W-1:0] noise_value;

	gnt_ctrl #(
		.MAX_OCTAVES(MAX_OCTAVES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_valid      (s_axis_tvalid),
		.s_ready      (s_axis_tready),
		.action       (s_axis_tuser),
		.octave_count (s_axis_tdata[180:176]),
		.m_valid      (m_axis_tvalid),
		.m_ready      (m_axis_tready),
		.status       (status),
		.cmd          (cmd)
	);

	gnt_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.table_index  (s_axis_tdata[7:0]),
		.perm_x_value (s_axis_tdata[15:8]),
		.perm_y_value (s_axis_tdata[23:16]),
		.perm_z_value (s_axis_tdata[31:24]),
		.grad_x       (s_axis_tdata[47:32]),
		.grad_y       (s_axis_tdata[63:48]),
		.grad_z       (s_axis_tdata[79:64]),
		.point_x      (s_axis_tdata[111:80]),
		.point_y      (s_axis_tdata[143:112]),
		.point_z      (s_axis_tdata[175:144]),
		.noise_value  (noise_value)
	);

	assign m_axis_tdata = {4'b0000, noise_value};

endmodule

>>> tb/tb_gradient_noise_turbulence_unit.sv
`timescale 1ns / 1ps
module tb_gradient_noise_turbulence_unit;
	import gnt_pkg::*;

	localparam int FB = 16;
	localparam int OCT_MAX = 16;
	localparam longint CYCLE_LIMIT = 2000000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// [7:0] index, [15:8] px, [23:16] py, [31:24] pz, [47:32] gx, [63:48] gy,
	// [79:64] gz, [111:80] point_x, [143:112] point_y, [175:144] point_z,
	// [180:176] octave_count
	logic [183:0] s_axis_tdata;
	// [1:0] action
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [19:0] noise_value
	logic [23:0]  m_axis_tdata;

	gradient_noise_turbulence_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// shadow copies of the lookup tables
	logic [7:0]         px_tab [256];
	logic [7:0]         py_tab [256];
	logic [7:0]         pz_tab [256];
	logic signed [15:0] g_tab  [256][3];
	bit                 written [256];

	logic [19:0] noise_expected [$];
	int          errors;
	int          results_seen;
	int          noise_items, turb_items, load_items;
	bit          idle_on;
	longint      cycles;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic longint fshift(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic longint smoothstep(longint f);
		longint sq;
		sq = (f * f) >>> FB;
		return (sq * (3 * (64'sd1 <<< FB) - 2 * f)) >>> FB;
	endfunction

	// one octave of gradient noise, Q.FB result
	function automatic longint octave_noise(logic [31:0] p [3]);
		longint one, f [3], s [3], wt [3], w, dot, acc, off;
		int cell_idx [3], g, d [3];
		one = 64'sd1 <<< FB;
		acc = 0;
		for (int a = 0; a < 3; a++) begin
			f[a] = longint'(p[a][FB-1:0]);
			cell_idx[a] = int'(p[a][FB+7:FB]);
			s[a] = smoothstep(f[a]);
		end
		for (int c = 0; c < 8; c++) begin
			d[0] = int'(c[2]); d[1] = int'(c[1]); d[2] = int'(c[0]);
			g = int'(px_tab[(cell_idx[0] + d[0]) & 255] ^ py_tab[(cell_idx[1] + d[1]) & 255]
				^ pz_tab[(cell_idx[2] + d[2]) & 255]);
			dot = 0;
			for (int a = 0; a < 3; a++) begin
				off = f[a] - (d[a] ? one : 0);
				wt[a] = d[a] ? s[a] : one - s[a];
				dot += longint'(g_tab[g][a]) * off;
			end
			dot = fshift(dot, GRAD_FRAC);
			w = (((wt[0] * wt[1]) >>> FB) * wt[2]) >>> FB;
			acc += dot * w;
		end
		return fshift(acc, FB);
	endfunction

	function automatic logic [19:0] to_q3_16(longint v);
		v = fshift(v, FB - OUT_FRAC);
		if (v > OUT_MAX) v = OUT_MAX;
		if (v < OUT_MIN) v = OUT_MIN;
		return v[19:0];
	endfunction

	function automatic logic [19:0] predict_noise(logic [1:0] act, logic [183:0] d);
		logic [31:0] p [3];
		longint acc;
		int n;
		p[0] = d[111:80]; p[1] = d[143:112]; p[2] = d[175:144];
		if (act == ACT_NOISE)
			return to_q3_16(octave_noise(p));
		n = int'(d[180:176]);
		if (n > OCT_MAX) n = OCT_MAX;
		acc = 0;
		for (int i = 0; i < n; i++) begin
			acc += fshift(octave_noise(p), i);
			for (int a = 0; a < 3; a++) p[a] = p[a] << 1;
		end
		if (acc < 0) acc = -acc;
		return to_q3_16(acc);
	endfunction

	// all cells reachable by a point hit written entries?
	function automatic bit cells_ok(logic [183:0] d, int n);
		logic [31:0] p [3];
		p[0] = d[111:80]; p[1] = d[143:112]; p[2] = d[175:144];
		if (n > OCT_MAX) n = OCT_MAX;
		for (int i = 0; i < n; i++) begin
			for (int a = 0; a < 3; a++) begin
				if (!written[p[a][FB+7:FB]] || !written[(p[a][FB+7:FB] + 1) & 255])
					return 0;
				p[a] = p[a] << 1;
			end
		end
		return 1;
	endfunction

	function automatic bit gates_open();
		return !idle_on || ($urandom_range(99) >= 38);
	endfunction

	// one transfer on the slave side; model updated at acceptance
	task automatic send_item(logic [1:0] act, logic [183:0] d);
		while (!gates_open()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser <= act;
		s_axis_tdata <= d;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		case (act)
			ACT_LOAD: begin
				px_tab[d[7:0]] = d[15:8];
				py_tab[d[7:0]] = d[23:16];
				pz_tab[d[7:0]] = d[31:24];
				g_tab[d[7:0]][0] = d[47:32];
				g_tab[d[7:0]][1] = d[63:48];
				g_tab[d[7:0]][2] = d[79:64];
				written[d[7:0]] = 1'b1;
				load_items++;
			end
			ACT_NOISE: begin
				noise_expected.push_back(predict_noise(act, d));
				noise_items++;
			end
			ACT_TURB: begin
				noise_expected.push_back(predict_noise(act, d));
				turb_items++;
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic [183:0] load_word(int idx, int a, int b, int c,
			int gx, int gy, int gz);
		logic [183:0] d;
		d = '0;
		d[7:0] = 8'(idx); d[15:8] = 8'(a); d[23:16] = 8'(b); d[31:24] = 8'(c);
		d[47:32] = 16'(gx); d[63:48] = 16'(gy); d[79:64] = 16'(gz);
		return d;
	endfunction

	function automatic logic [183:0] point_word(logic [31:0] x, logic [31:0] y,
			logic [31:0] z, int n);
		logic [183:0] d;
		d = '0;
		d[111:80] = x; d[143:112] = y; d[175:144] = z; d[180:176] = 5'(n);
		return d;
	endfunction

	function automatic int rand_grad();
		case ($urandom_range(5))
			0: return 16384;
			1: return -16384;
			2: return $urandom_range(65535); // any bit pattern incl. -32768
			default: return int'($urandom_range(32768)) - 16384;
		endcase
	endfunction

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (noise_expected.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	// fill every entry, corners of the field ranges first
	task automatic test_table_fill();
		send_item(ACT_LOAD, load_word(0, 0, 0, 0, 16384, -16384, 0));
		send_item(ACT_LOAD, load_word(255, 255, 255, 255, -32768, 32767, -16384));
		for (int i = 1; i < 255; i++)
			send_item(ACT_LOAD, load_word(i, $urandom_range(255), $urandom_range(255),
				$urandom_range(255), rand_grad(), rand_grad(), rand_grad()));
	endtask

	task automatic test_directed();
		send_item(ACT_NOISE, point_word(32'h0, 32'h0, 32'h0, 0));
		send_item(ACT_NOISE, point_word(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0));
		send_item(ACT_NOISE, point_word(32'h0000_8000, 32'h0001_4000, 32'h00ff_c000, 0));
		send_item(ACT_TURB, point_word(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 0));
		send_item(ACT_TURB, point_word(32'h0003_1111, 32'h0005_2222, 32'h0007_3333, 1));
		send_item(ACT_TURB, point_word(32'h0003_1111, 32'h0005_2222, 32'h0007_3333, 16));
		send_item(ACT_TURB, point_word(32'hdead_beef, 32'h0bad_cafe, 32'h1357_9bdf, 31));
		send_item(2'd3, ~184'h0);  // unused action, no result
		send_item(ACT_NOISE, point_word(32'hffff_0001, 32'h00ff_ffff, 32'h8000_ffff, 0));
	endtask

	// sender holds until the block has returned everything
	task automatic test_drain_pause();
		wait_drained();
		send_item(ACT_NOISE, point_word($urandom, $urandom, $urandom, 0));
	endtask

	task automatic test_random(int count);
		int k;
		for (k = 0; k < count; k++) begin
			if (k == count / 2) idle_on = 1'b0;
			if (k == count / 2 + 80) idle_on = 1'b1;
			case ($urandom_range(9))
				0, 1: send_item(ACT_LOAD, load_word($urandom_range(255),
					$urandom_range(255), $urandom_range(255), $urandom_range(255),
					rand_grad(), rand_grad(), rand_grad()));
				2: send_item(2'd3, 184'({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom}));
				3, 4, 5: send_item(ACT_NOISE, 184'({$urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom}));
				default: send_item(ACT_TURB, point_word($urandom, $urandom, $urandom,
					($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(4)));
			endcase
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (noise_expected.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				logic [19:0] want;
				want = noise_expected.pop_front();
				if (m_axis_tdata[19:0] !== want) begin
					errors++;
					if (errors <= 10)
						$display("noise_value mismatch: expected %h actual %h",
							want, m_axis_tdata[19:0]);
				end
			end
		end
	end

	always @(negedge clk) m_axis_tready <= gates_open();

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0; results_seen = 0; cycles = 0; idle_on = 1'b1;
		noise_items = 0; turb_items = 0; load_items = 0;
		for (int i = 0; i < 256; i++) written[i] = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_LOAD;
		m_axis_tready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_table_fill();
		test_directed();
		test_drain_pause();
		test_random(334);
		wait_drained();
		$display("covered %0d loads, %0d noise, %0d turbulence items, %0d results",
			load_items, noise_items, turb_items, results_seen);
		if (errors == 0 && noise_expected.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
